FILE: design/bctm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Block chain table manager package
// Shared constants, codes and bundles for the chain table manager.
// ----------------------------------------------------------------------------
package bctm_pkg;

  localparam int NumBlocks = 256;
  localparam int BlkW      = 8;
  localparam int LinkW     = BlkW + 1;
  localparam int CntW      = $clog2(NumBlocks + 1);
  localparam int HopW      = 8;
  localparam int CmdW      = 3;
  localparam int GrpSize   = 16;
  localparam int NumGrps   = NumBlocks / GrpSize;
  localparam int GrpW      = $clog2(NumGrps);
  localparam int OffW      = $clog2(GrpSize);

  localparam logic [LinkW-1:0] LinkEnd = '1;

  typedef enum logic [CmdW-1:0] {
    CMD_CREATE = 3'd0,
    CMD_APPEND = 3'd1,
    CMD_WALK   = 3'd2,
    CMD_COUNT  = 3'd3,
    CMD_FREE   = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_PAST_END  = 2'd2,
    ST_NOT_ALLOC = 2'd3
  } status_e;

  typedef struct packed {
    status_e             status;
    logic [BlkW-1:0]     block;
    logic [CntW-1:0]     total;
  } result_t;

  typedef struct packed {
    logic            en;
    logic [BlkW-1:0] idx;
    logic            val;
  } fm_wr_t;

  typedef struct packed {
    logic             we;
    logic             re;
    logic [BlkW-1:0]  addr;
    logic [LinkW-1:0] wdata;
  } ram_req_t;

endpackage
`default_nettype wire

FILE: design/bctm_link_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Link table RAM
// Single-port synchronous memory holding the next link of every block.
// ----------------------------------------------------------------------------
module bctm_link_ram (
  input  wire logic                      clk_i,
  input  wire bctm_pkg::ram_req_t        req_i,
  output logic [bctm_pkg::LinkW-1:0]     rdata_o
);
  import bctm_pkg::*;

  logic [LinkW-1:0] mem_q [NumBlocks];
  logic [LinkW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: design/bctm_free_map.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Free map
// One flag per block, set at reset, with a two-stage lowest-free finder.
// ----------------------------------------------------------------------------
module bctm_free_map (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire bctm_pkg::fm_wr_t        wr_i,
  input  wire logic [bctm_pkg::BlkW-1:0] chk_idx_i,
  output logic                         chk_free_o,
  output logic                         low_any_o,
  output logic [bctm_pkg::BlkW-1:0]    low_idx_o
);
  import bctm_pkg::*;

  logic [NumBlocks-1:0]  map_q;
  logic [NumGrps-1:0]    grp_any_d, grp_any_q;
  logic [OffW-1:0]       grp_off_d [NumGrps];
  logic [OffW-1:0]       grp_off_q [NumGrps];
  logic                  low_any_d, low_any_q;
  logic [BlkW-1:0]       low_idx_d, low_idx_q;
  logic [GrpW-1:0]       grp_sel;

  always_comb begin
    for (int g = 0; g < NumGrps; g++) begin
      grp_any_d[g] = |map_q[g*GrpSize +: GrpSize];
      grp_off_d[g] = '0;
      for (int k = GrpSize - 1; k >= 0; k--) begin
        if (map_q[g*GrpSize + k]) begin
          grp_off_d[g] = OffW'(k);
        end
      end
    end
  end

  always_comb begin
    grp_sel = '0;
    for (int g = NumGrps - 1; g >= 0; g--) begin
      if (grp_any_q[g]) begin
        grp_sel = GrpW'(g);
      end
    end
    low_any_d = |grp_any_q;
    low_idx_d = {grp_sel, grp_off_q[grp_sel]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q     <= '1;
      grp_any_q <= '1;
      for (int g = 0; g < NumGrps; g++) begin
        grp_off_q[g] <= '0;
      end
      low_any_q <= 1'b1;
      low_idx_q <= '0;
    end else begin
      if (wr_i.en) begin
        map_q[wr_i.idx] <= wr_i.val;
      end
      grp_any_q <= grp_any_d;
      for (int g = 0; g < NumGrps; g++) begin
        grp_off_q[g] <= grp_off_d[g];
      end
      low_any_q <= low_any_d;
      low_idx_q <= low_idx_d;
    end
  end

  assign chk_free_o = map_q[chk_idx_i];
  assign low_any_o  = low_any_q;
  assign low_idx_o  = low_idx_q;

endmodule
`default_nettype wire

FILE: design/bctm_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Chain controller
// Sequencer that decodes a command, chases links through the RAM and
// updates the free map and link table.
// ----------------------------------------------------------------------------
module bctm_ctrl (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [bctm_pkg::CmdW-1:0]   command_i,
  input  wire logic [bctm_pkg::BlkW-1:0]   block_index_i,
  input  wire logic [bctm_pkg::HopW-1:0]   hop_count_i,
  output logic [bctm_pkg::BlkW-1:0]        chk_idx_o,
  input  wire logic                        chk_free_i,
  input  wire logic                        low_any_i,
  input  wire logic [bctm_pkg::BlkW-1:0]   low_idx_i,
  output bctm_pkg::fm_wr_t                 fm_wr_o,
  output bctm_pkg::ram_req_t               ram_req_o,
  input  wire logic [bctm_pkg::LinkW-1:0]  ram_rdata_i,
  output logic                             res_valid_o,
  input  wire logic                        res_ready_i,
  output bctm_pkg::result_t                res_o
);
  import bctm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND1,
    S_FIND2,
    S_DISPATCH,
    S_READ,
    S_EVAL,
    S_LINK,
    S_DONE
  } state_e;

  state_e            state_d, state_q;
  cmd_e              cmd_d, cmd_q;
  logic [BlkW-1:0]   blk_d, blk_q;
  logic [BlkW-1:0]   cur_d, cur_q;
  logic [BlkW-1:0]   nb_d, nb_q;
  logic [HopW-1:0]   hops_d, hops_q;
  logic [CntW-1:0]   cnt_d, cnt_q;
  result_t           res_d, res_q;
  logic [CntW-1:0]   cnt_inc;
  logic              nx_end;
  logic [BlkW-1:0]   nx_blk;

  assign cnt_inc = cnt_q + CntW'(1);
  assign nx_end  = ram_rdata_i[LinkW-1];
  assign nx_blk  = ram_rdata_i[BlkW-1:0];

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    blk_d      = blk_q;
    cur_d      = cur_q;
    nb_d       = nb_q;
    hops_d     = hops_q;
    cnt_d      = cnt_q;
    res_d      = res_q;
    in_ready_o = 1'b0;
    fm_wr_o    = '0;
    ram_req_o  = '0;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_d   = cmd_e'(command_i);
          blk_d   = block_index_i;
          cur_d   = block_index_i;
          hops_d  = hop_count_i;
          cnt_d   = '0;
          state_d = S_FIND1;
        end
      end
      S_FIND1: state_d = S_FIND2;
      S_FIND2: state_d = S_DISPATCH;
      S_DISPATCH: begin
        res_d   = '{status: ST_OK, block: '0, total: '0};
        nb_d    = low_idx_i;
        state_d = S_DONE;
        case (cmd_q)
          CMD_CREATE: begin
            if (!low_any_i) begin
              res_d.status = ST_NO_FREE;
            end else begin
              fm_wr_o   = '{en: 1'b1, idx: low_idx_i, val: 1'b0};
              ram_req_o = '{we: 1'b1, re: 1'b0, addr: low_idx_i, wdata: LinkEnd};
              res_d.block = low_idx_i;
            end
          end
          CMD_APPEND, CMD_WALK, CMD_COUNT, CMD_FREE: begin
            if (chk_free_i) begin
              res_d.status = ST_NOT_ALLOC;
            end else if (cmd_q == CMD_APPEND && !low_any_i) begin
              res_d.status = ST_NO_FREE;
            end else if (cmd_q == CMD_WALK && hops_q == '0) begin
              res_d.block = blk_q;
            end else begin
              state_d = S_READ;
            end
          end
          default: ;
        endcase
      end
      S_READ: begin
        ram_req_o = '{we: 1'b0, re: 1'b1, addr: cur_q, wdata: '0};
        state_d   = S_EVAL;
      end
      S_EVAL: begin
        case (cmd_q)
          CMD_WALK: begin
            if (nx_end) begin
              res_d.status = ST_PAST_END;
              state_d      = S_DONE;
            end else begin
              cur_d = nx_blk;
              cnt_d = cnt_inc;
              if (cnt_inc == CntW'(hops_q)) begin
                res_d.block = nx_blk;
                state_d     = S_DONE;
              end else begin
                state_d = S_READ;
              end
            end
          end
          CMD_COUNT, CMD_APPEND: begin
            if (!nx_end) begin
              cur_d = nx_blk;
              cnt_d = cnt_inc;
            end
            if (nx_end || cnt_inc == CntW'(NumBlocks)) begin
              if (cmd_q == CMD_COUNT) begin
                res_d.total = nx_end ? cnt_q : cnt_inc;
                state_d     = S_DONE;
              end else begin
                fm_wr_o   = '{en: 1'b1, idx: nb_q, val: 1'b0};
                ram_req_o = '{we: 1'b1, re: 1'b0, addr: nb_q, wdata: LinkEnd};
                state_d   = S_LINK;
              end
            end else begin
              state_d = S_READ;
            end
          end
          CMD_FREE: begin
            fm_wr_o = '{en: 1'b1, idx: cur_q, val: 1'b1};
            cnt_d   = cnt_inc;
            if (nx_end || cnt_inc == CntW'(NumBlocks)) begin
              res_d.total = cnt_inc;
              state_d     = S_DONE;
            end else begin
              cur_d   = nx_blk;
              state_d = S_READ;
            end
          end
          default: state_d = S_DONE;
        endcase
      end
      S_LINK: begin
        ram_req_o   = '{we: 1'b1, re: 1'b0, addr: cur_q, wdata: {1'b0, nb_q}};
        res_d.block = nb_q;
        state_d     = S_DONE;
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cmd_q   <= CMD_CREATE;
      blk_q   <= '0;
      cur_q   <= '0;
      nb_q    <= '0;
      hops_q  <= '0;
      cnt_q   <= '0;
      res_q   <= '{status: ST_OK, block: '0, total: '0};
    end else begin
      state_q <= state_d;
      cmd_q   <= cmd_d;
      blk_q   <= blk_d;
      cur_q   <= cur_d;
      nb_q    <= nb_d;
      hops_q  <= hops_d;
      cnt_q   <= cnt_d;
      res_q   <= res_d;
    end
  end

  assign chk_idx_o   = blk_q;
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

`ifndef SYNTHESIS
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_ready_i |=> res_valid_o && $stable(res_q))
    else $error("result changed while stalled");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(NumBlocks))
    else $error("link count beyond block count");

  a_past_end_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_q.status == ST_PAST_END |-> cmd_q == CMD_WALK)
    else $error("past-end status from a non-walk command");

  a_ram_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_req_o.we |-> !ram_req_o.re && !in_ready_o)
    else $error("link write overlaps a read or an idle cycle");
`endif

endmodule
`default_nettype wire

FILE: design/block_chain_table_manager_unit.sv
`default_nettype none
// Sequence after accept: S_FIND1, S_FIND2 and S_DISPATCH, then an S_READ/S_EVAL
//   pair per link table read (walk at most one per hop, free one per block, count
//   and append links + 1, at most 256), S_LINK for the append tail write, and
//   S_DONE. One command at a time; the next is taken once the result leaves the
//   controller, even while that beat waits at the output.
// Reset: free map all free, controller idle, output empty; link table not cleared.
// ----------------------------------------------------------------------------
// Block chain table manager
// Top level: free map, link RAM, controller and output register.
// ----------------------------------------------------------------------------
module block_chain_table_manager_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [bctm_pkg::CmdW-1:0]   command_i,
  input  wire logic [bctm_pkg::BlkW-1:0]   block_index_i,
  input  wire logic [bctm_pkg::HopW-1:0]   hop_count_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [1:0]                       status_o,
  output logic [bctm_pkg::BlkW-1:0]        result_block_o,
  output logic [bctm_pkg::CntW-1:0]        link_total_o
);
  import bctm_pkg::*;

  fm_wr_t           fm_wr;
  ram_req_t         ram_req;
  logic [LinkW-1:0] ram_rdata;
  logic [BlkW-1:0]  chk_idx;
  logic             chk_free;
  logic             low_any;
  logic [BlkW-1:0]  low_idx;
  logic             res_valid;
  logic             res_ready;
  result_t          res;
  logic             out_valid_q;
  result_t          out_q;

  bctm_free_map u_free_map (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (fm_wr),
    .chk_idx_i  (chk_idx),
    .chk_free_o (chk_free),
    .low_any_o  (low_any),
    .low_idx_o  (low_idx)
  );

  bctm_link_ram u_link_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  bctm_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .block_index_i (block_index_i),
    .hop_count_i   (hop_count_i),
    .chk_idx_o     (chk_idx),
    .chk_free_i    (chk_free),
    .low_any_i     (low_any),
    .low_idx_i     (low_idx),
    .fm_wr_o       (fm_wr),
    .ram_req_o     (ram_req),
    .ram_rdata_i   (ram_rdata),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_q.status;
  assign result_block_o = out_q.block;
  assign link_total_o   = out_q.total;

endmodule
`default_nettype wire

FILE: tb/tb_block_chain_table_manager_unit.sv
// ----------------------------------------------------------------------------
// Testbench for the block chain table manager
// Drives create, append, walk, count and free commands through the valid/ready
// input, predicts every result beat from a local copy of the link table and
// free map, and checks each beat field by field under random idling on both
// sides. Covers empty and full tables, looping chains and unknown commands.
// ----------------------------------------------------------------------------
module tb_block_chain_table_manager_unit;
  import bctm_pkg::*;

  localparam int WatchdogLimit = 3000;
  localparam int DrainCycles   = 40;

  localparam logic [CmdW-1:0] CmdFirstUnused = 3'd5;
  localparam logic [CmdW-1:0] CmdLastUnused  = 3'd7;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  logic [CmdW-1:0]  command_i;
  logic [BlkW-1:0]  block_index_i;
  logic [HopW-1:0]  hop_count_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic [1:0]       status_o;
  logic [BlkW-1:0]  result_block_o;
  logic [CntW-1:0]  link_total_o;

  block_chain_table_manager_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .block_index_i  (block_index_i),
    .hop_count_i    (hop_count_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .result_block_o (result_block_o),
    .link_total_o   (link_total_o)
  );

  logic [LinkW-1:0] link_tbl [NumBlocks];
  bit               blk_free [NumBlocks];
  result_t          pending_results [$];
  result_t          head_r;

  int  err_cnt;
  int  stall_cycles;
  int  rx_stall;
  bit  burst;
  int  cmd_sent [8];
  int  status_seen [4];
  int  max_total;

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  function automatic result_t run_table_cmd(logic [CmdW-1:0] cmd, logic [BlkW-1:0] blk,
                                            logic [HopW-1:0] hops);
    result_t          res;
    int               nb;
    int               b;
    int               n;
    bit               done;
    logic [LinkW-1:0] nx;
    res.status = ST_OK;
    res.block  = '0;
    res.total  = '0;
    nb = NumBlocks;
    for (int i = NumBlocks - 1; i >= 0; i--) begin
      if (blk_free[i]) nb = i;
    end
    if (cmd == CMD_CREATE) begin
      if (nb >= NumBlocks) begin
        res.status = ST_NO_FREE;
      end else begin
        blk_free[nb] = 1'b0;
        link_tbl[nb] = LinkEnd;
        res.block    = 8'(nb);
      end
    end else if (cmd <= CMD_FREE) begin
      b = blk;
      n = 0;
      done = 1'b0;
      if (blk_free[blk]) begin
        res.status = ST_NOT_ALLOC;
      end else if (cmd == CMD_APPEND) begin
        if (nb >= NumBlocks) begin
          res.status = ST_NO_FREE;
        end else begin
          while (n < NumBlocks && link_tbl[b] < NumBlocks) begin
            b = link_tbl[b];
            n++;
          end
          blk_free[nb] = 1'b0;
          link_tbl[nb] = LinkEnd;
          link_tbl[b]  = 9'(nb);
          res.block    = 8'(nb);
        end
      end else if (cmd == CMD_WALK) begin
        while (n < hops && !done) begin
          if (link_tbl[b] >= NumBlocks) begin
            res.status = ST_PAST_END;
            done = 1'b1;
          end else begin
            b = link_tbl[b];
            n++;
          end
        end
        if (!done) res.block = 8'(b);
      end else if (cmd == CMD_COUNT) begin
        while (n < NumBlocks && link_tbl[b] < NumBlocks) begin
          b = link_tbl[b];
          n++;
        end
        res.total = 9'(n);
      end else begin
        while (n < NumBlocks && !done) begin
          nx = link_tbl[b];
          blk_free[b] = 1'b1;
          n++;
          if (nx >= NumBlocks) done = 1'b1;
          else b = nx;
        end
        res.total = 9'(n);
      end
    end
    return res;
  endfunction

  function automatic logic [BlkW-1:0] pick_allocated();
    int taken [$];
    for (int i = 0; i < NumBlocks; i++) begin
      if (!blk_free[i]) taken.push_back(i);
    end
    if (taken.size() == 0) return 8'($urandom_range(0, NumBlocks - 1));
    return 8'(taken[$urandom_range(0, taken.size() - 1)]);
  endfunction

  function automatic int free_blocks();
    int n;
    n = 0;
    for (int i = 0; i < NumBlocks; i++) begin
      if (blk_free[i]) n++;
    end
    return n;
  endfunction

  task automatic send_cmd(input logic [CmdW-1:0] cmd, input logic [BlkW-1:0] blk,
                          input logic [HopW-1:0] hops);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    command_i     <= cmd;
    block_index_i <= blk;
    hop_count_i   <= hops;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_results.push_back(run_table_cmd(cmd, blk, hops));
    cmd_sent[cmd]++;
  endtask

  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed_cases();
    burst = 1'b0;
    // empty table: every chain command hits an unallocated block
    send_cmd(CMD_WALK, 8'd0, 8'd0);
    send_cmd(CMD_COUNT, 8'd255, 8'd0);
    send_cmd(CMD_FREE, 8'd128, 8'd255);
    send_cmd(CMD_APPEND, 8'd0, 8'd0);
    send_cmd(CmdFirstUnused, 8'd255, 8'd255);
    send_cmd(CmdFirstUnused + 3'd1, 8'd0, 8'd0);
    send_cmd(CmdLastUnused, 8'd170, 8'd85);
    // build 0 -> 1 -> 2 -> 3, appending through an inner block
    send_cmd(CMD_CREATE, 8'd255, 8'd255);
    send_cmd(CMD_APPEND, 8'd0, 8'd0);
    send_cmd(CMD_APPEND, 8'd0, 8'd0);
    send_cmd(CMD_APPEND, 8'd1, 8'd0);
    send_cmd(CMD_WALK, 8'd0, 8'd0);
    send_cmd(CMD_WALK, 8'd0, 8'd3);
    send_cmd(CMD_WALK, 8'd0, 8'd4);
    send_cmd(CMD_WALK, 8'd0, 8'd255);
    send_cmd(CMD_COUNT, 8'd0, 8'd0);
    // release the tail, then append through the stale link: self loop at the tail
    send_cmd(CMD_FREE, 8'd3, 8'd0);
    send_cmd(CMD_APPEND, 8'd2, 8'd0);
    send_cmd(CMD_COUNT, 8'd0, 8'd0);
    send_cmd(CMD_WALK, 8'd0, 8'd255);
    send_cmd(CMD_APPEND, 8'd0, 8'd0);
    send_cmd(CMD_FREE, 8'd4, 8'd0);
    send_cmd(CMD_APPEND, 8'd3, 8'd0);
    send_cmd(CMD_FREE, 8'd0, 8'd0);
    send_cmd(CMD_CREATE, 8'd0, 8'd0);
    wait_results_drained();
  endtask

  task automatic test_table_exhaustion();
    burst = 1'b0;
    while (free_blocks() > 0) begin
      if ($urandom_range(0, 4) == 0) begin
        send_cmd(CMD_CREATE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end else begin
        send_cmd(CMD_APPEND, pick_allocated(), 8'($urandom_range(0, 255)));
      end
    end
    send_cmd(CMD_CREATE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    send_cmd(CMD_APPEND, pick_allocated(), 8'($urandom_range(0, 255)));
    repeat (4) begin
      send_cmd(CMD_WALK, pick_allocated(), 8'd255);
      send_cmd(CMD_WALK, pick_allocated(), 8'($urandom_range(0, 16)));
      send_cmd(CMD_COUNT, pick_allocated(), 8'($urandom_range(0, 255)));
    end
    // hold off until the full table has answered everything
    wait_results_drained();
    burst = 1'b1;
    while (free_blocks() < NumBlocks) begin
      send_cmd(CMD_FREE, pick_allocated(), 8'($urandom_range(0, 255)));
    end
    wait_results_drained();
  endtask

  task automatic test_random_traffic();
    int              grow;
    int              r;
    logic [CmdW-1:0] cmd;
    logic [BlkW-1:0] blk;
    logic [HopW-1:0] hops;
    for (int seg = 0; seg < 10; seg++) begin
      grow  = (seg % 2 == 0) ? 80 : 20;
      burst = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < 100; k++) begin
        r    = $urandom_range(0, 99);
        blk  = pick_allocated();
        case ($urandom_range(0, 3))
          0:       hops = 8'($urandom_range(0, 255));
          3:       hops = 8'($urandom_range(0, 32));
          default: hops = 8'($urandom_range(0, 8));
        endcase
        if (r < 3) begin
          cmd = 3'($urandom_range(CmdFirstUnused, CmdLastUnused));
          blk = 8'($urandom_range(0, 255));
        end else if (r < 8) begin
          cmd = 3'($urandom_range(CMD_APPEND, CMD_FREE));
          blk = 8'($urandom_range(0, 255));
        end else if ($urandom_range(0, 99) < grow) begin
          cmd = ($urandom_range(0, 2) == 0) ? CMD_CREATE : CMD_APPEND;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 45) cmd = CMD_WALK;
          else if (r < 75) cmd = CMD_COUNT;
          else cmd = CMD_FREE;
        end
        send_cmd(cmd, blk, hops);
      end
      if (seg == 4) wait_results_drained();
    end
    wait_results_drained();
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= WatchdogLimit) begin
        $display("tb_block_chain_table_manager_unit: errors");
        $finish;
      end
      if (out_valid_o && out_ready_i) begin
        status_seen[status_o]++;
        if (link_total_o > max_total) max_total = link_total_o;
        if (pending_results.size() == 0) begin
          $error("result beat with no command outstanding");
          err_cnt++;
        end else begin
          head_r = pending_results.pop_front();
          if (status_o !== head_r.status) begin
            $error("status: expected %0d, got %0d", head_r.status, status_o);
            err_cnt++;
          end
          if (result_block_o !== head_r.block) begin
            $error("result_block: expected %0d, got %0d", head_r.block, result_block_o);
            err_cnt++;
          end
          if (link_total_o !== head_r.total) begin
            $error("link_total: expected %0d, got %0d", head_r.total, link_total_o);
            err_cnt++;
          end
        end
        rx_stall = burst ? 0 : $urandom_range(0, 5);
        if (rx_stall > 0) out_ready_i <= 1'b0;
      end else if (!out_ready_i) begin
        if (rx_stall > 0) rx_stall--;
        if (rx_stall == 0) out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    command_i     = '0;
    block_index_i = '0;
    hop_count_i   = '0;
    out_ready_i   = 1'b0;
    err_cnt       = 0;
    stall_cycles  = 0;
    rx_stall      = 0;
    burst         = 1'b0;
    max_total     = 0;
    for (int i = 0; i < NumBlocks; i++) begin
      link_tbl[i] = '0;
      blk_free[i] = 1'b1;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_table_exhaustion();
    test_random_traffic();

    repeat (DrainCycles) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d result beats never arrived", pending_results.size());
      err_cnt++;
    end
    $display("commands: create %0d, append %0d, walk %0d, count %0d, free %0d, unused %0d",
             cmd_sent[CMD_CREATE], cmd_sent[CMD_APPEND], cmd_sent[CMD_WALK],
             cmd_sent[CMD_COUNT], cmd_sent[CMD_FREE],
             cmd_sent[5] + cmd_sent[6] + cmd_sent[7]);
    $display("statuses: ok %0d, no free %0d, past end %0d, not allocated %0d; max total %0d",
             status_seen[ST_OK], status_seen[ST_NO_FREE], status_seen[ST_PAST_END],
             status_seen[ST_NOT_ALLOC], max_total);
    if (err_cnt == 0) begin
      $display("tb_block_chain_table_manager_unit: clean");
    end else begin
      $display("tb_block_chain_table_manager_unit: errors");
    end
    $finish;
  end

endmodule
